[rtl/clcd_pkg.sv]
// Shared types, constants and the control program of the character LCD byte writer.
// Used by clcd_sequencer and char_lcd_i2c_byte_writer; depends on nothing else.
package clcd_pkg;

  localparam int unsigned PC_W  = 4;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned BIN_W = 32;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_CONV   = 4'd0;
  localparam pc_t PC_SETCNT = 4'd1;
  localparam pc_t PC_SKIP   = 4'd2;
  localparam pc_t PC_LOAD   = 4'd3;
  localparam pc_t PC_ADDR   = 4'd4;
  localparam pc_t PC_HI_EN  = 4'd5;
  localparam pc_t PC_HI_DIS = 4'd6;
  localparam pc_t PC_LO_EN  = 4'd7;
  localparam pc_t PC_LO_DIS = 4'd8;
  localparam pc_t PC_NEXT   = 4'd9;

  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(BIN_W - 1);

  localparam logic [7:0] ADDR_RESET    = 8'h4E;
  localparam logic [7:0] NIB_MASK      = 8'hF0;
  localparam logic [7:0] BACKLIGHT_BIT = 8'h08;
  localparam logic [7:0] ENABLE_BIT    = 8'h04;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_DATA   = 2'd1,
    OP_NUM    = 2'd2,
    OP_CURSOR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    DP_NOP    = 3'd0,
    DP_DABBLE = 3'd1,
    DP_SETCNT = 3'd2,
    DP_SKIP   = 3'd3,
    DP_LOAD   = 3'd4,
    DP_NEXT   = 3'd5
  } dp_op_e;

  typedef enum logic [2:0] {
    EM_NONE   = 3'd0,
    EM_ADDR   = 3'd1,
    EM_HI_EN  = 3'd2,
    EM_HI_DIS = 3'd3,
    EM_LO_EN  = 3'd4,
    EM_LO_DIS = 3'd5
  } emit_e;

  typedef enum logic [2:0] {
    C_FALL = 3'd0,
    C_LOOP = 3'd1,
    C_SKIP = 3'd2,
    C_MORE = 3'd3,
    C_END  = 3'd4
  } cond_e;

  typedef struct packed {
    dp_op_e op;
    emit_e  emit;
    cond_e  cond;
    pc_t    target;
  } uword_t;

  typedef struct packed {
    logic   take;
    dp_op_e op;
    emit_e  emit;
  } seq_ctrl_t;

  typedef struct packed {
    logic cnt_zero;
    logic lead_zero;
    logic num;
  } dp_stat_t;

  function automatic uword_t rom(pc_t pc);
    uword_t w;
    w = '{op: DP_NOP, emit: EM_NONE, cond: C_END, target: PC_CONV};
    case (pc)
      PC_CONV:   w = '{op: DP_DABBLE, emit: EM_NONE,   cond: C_LOOP, target: PC_CONV};
      PC_SETCNT: w = '{op: DP_SETCNT, emit: EM_NONE,   cond: C_FALL, target: PC_CONV};
      PC_SKIP:   w = '{op: DP_SKIP,   emit: EM_NONE,   cond: C_SKIP, target: PC_SKIP};
      PC_LOAD:   w = '{op: DP_LOAD,   emit: EM_NONE,   cond: C_FALL, target: PC_CONV};
      PC_ADDR:   w = '{op: DP_NOP,    emit: EM_ADDR,   cond: C_FALL, target: PC_CONV};
      PC_HI_EN:  w = '{op: DP_NOP,    emit: EM_HI_EN,  cond: C_FALL, target: PC_CONV};
      PC_HI_DIS: w = '{op: DP_NOP,    emit: EM_HI_DIS, cond: C_FALL, target: PC_CONV};
      PC_LO_EN:  w = '{op: DP_NOP,    emit: EM_LO_EN,  cond: C_FALL, target: PC_CONV};
      PC_LO_DIS: w = '{op: DP_NOP,    emit: EM_LO_DIS, cond: C_FALL, target: PC_CONV};
      PC_NEXT:   w = '{op: DP_NEXT,   emit: EM_NONE,   cond: C_MORE, target: PC_LOAD};
      default:   w = '{op: DP_NOP,    emit: EM_NONE,   cond: C_END,  target: PC_CONV};
    endcase
    return w;
  endfunction

endpackage

[rtl/clcd_sequencer.sv]
// Step counter and control store of the character LCD byte writer.
// Depends on clcd_pkg for the control word layout and the program.
module clcd_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                go_i,
  input  logic                go_num_i,
  input  clcd_pkg::dp_stat_t  stat_i,
  output clcd_pkg::seq_ctrl_t ctrl_o,
  output logic                running_o
);

  logic            running_q, running_d;
  clcd_pkg::pc_t   pc_q, pc_d;
  clcd_pkg::uword_t uw;
  logic            take;

  assign uw = clcd_pkg::rom(pc_q);

  always_comb begin
    case (uw.cond)
      clcd_pkg::C_LOOP: take = !stat_i.cnt_zero;
      clcd_pkg::C_SKIP: take = stat_i.lead_zero && !stat_i.cnt_zero;
      clcd_pkg::C_MORE: take = stat_i.num && !stat_i.cnt_zero;
      default:          take = 1'b0;
    endcase
  end

  always_comb begin
    running_d = running_q;
    pc_d      = pc_q;
    if (!running_q) begin
      if (go_i) begin
        running_d = 1'b1;
        pc_d      = go_num_i ? clcd_pkg::PC_CONV : clcd_pkg::PC_ADDR;
      end
    end else if (take) begin
      pc_d = uw.target;
    end else if (uw.cond == clcd_pkg::C_END || uw.cond == clcd_pkg::C_MORE) begin
      running_d = 1'b0;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pc_q      <= clcd_pkg::PC_CONV;
    end else begin
      running_q <= running_d;
      pc_q      <= pc_d;
    end
  end

  assign ctrl_o.take   = take;
  assign ctrl_o.op     = running_q ? uw.op : clcd_pkg::DP_NOP;
  assign ctrl_o.emit   = running_q ? uw.emit : clcd_pkg::EM_NONE;
  assign running_o     = running_q;

endmodule

[rtl/char_lcd_i2c_byte_writer.sv]
// Character LCD byte writer: turns display requests into I2C expander bytes.
// Command, data or cursor move: address byte, then each nibble with enable set and cleared.
// Number: a bit-serial decimal conversion, then leading zero digits are skipped and each
// remaining digit is loaded as ASCII and sent the same way, one transaction per digit.
// One request at a time; results cannot be stalled. Reset clears the sequencer
// and the output strobe and loads the address byte with 0x4E.
module char_lcd_i2c_byte_writer #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  column_i,
  input  logic        row_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        strobe_o,
  output logic [7:0]  bus_byte_o,
  output logic        start_before_o,
  output logic        stop_after_o,
  output logic        last_o
);

  localparam int unsigned BCD_W = 4 * MAX_DIGITS;

  logic                          accept;
  logic                          is_num;
  clcd_pkg::seq_ctrl_t           ctrl;
  clcd_pkg::dp_stat_t            stat;
  logic                          running;

  logic [7:0]                    addr_q;
  logic [7:0]                    byte_q;
  logic                          rs_q;
  logic                          num_q;
  logic [clcd_pkg::BIN_W-1:0]    bin_q;
  logic [BCD_W-1:0]              bcd_q, bcd_adj;
  logic                          ovf_q;
  logic [clcd_pkg::CNT_W-1:0]    cnt_q;
  logic [3:0]                    top_digit;
  logic [7:0]                    hi_nib, lo_nib;

  logic                          strobe_q, strobe_d;
  logic [7:0]                    out_byte_q, out_byte_d;
  logic                          start_q, start_d;
  logic                          stop_q, stop_d;
  logic                          last_q, last_d;

  assign accept = start && !running;
  assign is_num = (operation_i == clcd_pkg::OP_NUM);
  assign busy   = running;
  assign cfg_ready_o = 1'b1;

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  assign stat.cnt_zero  = (cnt_q == '0);
  assign stat.lead_zero = (top_digit == 4'd0) && !ovf_q;
  assign stat.num       = num_q;

  clcd_sequencer u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (accept),
    .go_num_i  (is_num),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .running_o (running)
  );

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                      : bcd_q[4*i +: 4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= clcd_pkg::ADDR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      addr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q <= is_num;
      rs_q  <= (operation_i == clcd_pkg::OP_DATA) || is_num;
      if (operation_i == clcd_pkg::OP_CURSOR) begin
        byte_q <= {1'b1, row_i, column_i};
      end else begin
        byte_q <= value_i[7:0];
      end
      bin_q <= value_i;
      bcd_q <= '0;
      ovf_q <= 1'b0;
      cnt_q <= clcd_pkg::CONV_LAST;
    end else begin
      case (ctrl.op)
        clcd_pkg::DP_DABBLE: begin
          bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[clcd_pkg::BIN_W-1]};
          ovf_q <= ovf_q | bcd_adj[BCD_W-1];
          bin_q <= bin_q << 1;
          cnt_q <= cnt_q - 1'b1;
        end
        clcd_pkg::DP_SETCNT: begin
          cnt_q <= clcd_pkg::CNT_W'(MAX_DIGITS - 1);
        end
        clcd_pkg::DP_SKIP, clcd_pkg::DP_NEXT: begin
          if (ctrl.take) begin
            bcd_q <= bcd_q << 4;
            cnt_q <= cnt_q - 1'b1;
          end
        end
        clcd_pkg::DP_LOAD: begin
          byte_q <= {clcd_pkg::ASCII_DIGIT_HI, top_digit};
        end
        default: begin
        end
      endcase
    end
  end

  assign hi_nib = (byte_q & clcd_pkg::NIB_MASK) | clcd_pkg::BACKLIGHT_BIT | {7'd0, rs_q};
  assign lo_nib = ((byte_q << 4) & clcd_pkg::NIB_MASK) | clcd_pkg::BACKLIGHT_BIT
                  | {7'd0, rs_q};

  always_comb begin
    strobe_d   = 1'b1;
    start_d    = 1'b0;
    stop_d     = 1'b0;
    last_d     = 1'b0;
    out_byte_d = out_byte_q;
    case (ctrl.emit)
      clcd_pkg::EM_ADDR: begin
        out_byte_d = addr_q;
        start_d    = 1'b1;
      end
      clcd_pkg::EM_HI_EN:  out_byte_d = hi_nib | clcd_pkg::ENABLE_BIT;
      clcd_pkg::EM_HI_DIS: out_byte_d = hi_nib & ~clcd_pkg::ENABLE_BIT;
      clcd_pkg::EM_LO_EN:  out_byte_d = lo_nib | clcd_pkg::ENABLE_BIT;
      clcd_pkg::EM_LO_DIS: begin
        out_byte_d = lo_nib & ~clcd_pkg::ENABLE_BIT;
        stop_d     = 1'b1;
        last_d     = !(num_q && !stat.cnt_zero);
      end
      default: strobe_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    start_q    <= start_d;
    stop_q     <= stop_d;
    last_q     <= last_d;
  end

  assign strobe_o       = strobe_q;
  assign bus_byte_o     = out_byte_q;
  assign start_before_o = start_q;
  assign stop_after_o   = stop_q;
  assign last_o         = last_q;

  // The final result of a request always closes a transaction with a stop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> stop_after_o)
    else $error("last result without stop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && start_before_o |-> !stop_after_o && !last_o)
    else $error("address byte flagged as end of transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(strobe_o && last_o))
    else $error("request ended without its last result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result produced while idle");

endmodule
